/* hw/rtl/tfr_pkg.sv */
// ----------------------------------------------------------------------------
// tfr_pkg: shared types and constants for the text find-and-replace block
// Field widths, operation and status codes, and the case-fold helper.
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam int TEXT_DEPTH   = 4096;
    localparam int STRING_DEPTH = 256;
    localparam int TAW = $clog2(TEXT_DEPTH);
    localparam int SAW = $clog2(STRING_DEPTH);
    localparam int TCW = TAW + 1;
    localparam int SCW = SAW + 1;

    localparam logic [2:0] OP_APP_TEXT = 3'd0;
    localparam logic [2:0] OP_APP_PAT  = 3'd1;
    localparam logic [2:0] OP_APP_REP  = 3'd2;
    localparam logic [2:0] OP_EXECUTE  = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  data_byte;
        logic [11:0] read_index;
    } tfr_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] match_index;
        logic [11:0] text_length;
        logic [7:0]  read_byte;
    } tfr_out_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

endpackage

/* hw/rtl/tfr_if.sv */
// ----------------------------------------------------------------------------
// tfr_if: valid/ready channel carrying one item
// Generic over the payload type.
// ----------------------------------------------------------------------------
interface tfr_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/text_find_replace_top.sv */
// ----------------------------------------------------------------------------
// text_find_replace_top: case-insensitive last-match find and replace
// Text, pattern and replacement stores with a sequencer for execute.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (operation, data_byte, read_index); one result
// item per input item leaves on out_ch. text_limit must be written through
// cfg_we/cfg_data only while idle; the block itself does not enforce this.
// Append, clear, unused codes and an execute that fails up front go
// straight to the result; read first passes through a registered memory
// read. Execute runs one memory access per cycle on a single text port:
// the backward search reads and then compares each byte, then the tail
// move reads and writes each moved byte and the replacement copy reads and
// writes each byte. The text RAM port is the limit on all of this.
// The block takes no item while an item is at work or its result waits;
// a stalled receiver simply holds the result register.
// Reset clears counts and sets text_limit to 4095; store contents stay
// undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module text_find_replace_top
    import tfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data,
    tfr_if.sink         in_ch,
    tfr_if.source       out_ch
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDW   = 9'b000000010,
        S_SRCH  = 9'b000000100,
        S_SCMP  = 9'b000001000,
        S_MVRD  = 9'b000010000,
        S_MVWR  = 9'b000100000,
        S_CPRD  = 9'b001000000,
        S_CPWR  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    logic [TAW-1:0] tcnt_reg;
    logic [SCW-1:0] pcnt_reg, rcnt_reg;
    logic [11:0] limit_reg;
    tfr_in_t  item_reg;
    tfr_out_t res_reg;

    // memories
    logic [7:0] text_mem [TEXT_DEPTH];
    logic [7:0] pat_mem  [STRING_DEPTH];
    logic [7:0] rep_mem  [STRING_DEPTH];
    logic [7:0] tq_reg, pq_reg, rq_reg;

    // sequencer working registers
    logic [TCW-1:0] pos_reg;     // candidate start + 1 (search) / move index
    logic [SCW-1:0] k_reg;       // offset within pattern / replacement
    logic [TAW-1:0] loc_reg;
    logic [TAW-1:0] mvcnt_reg;   // bytes left to move
    logic           grow_reg;
    logic [7:0]     hold_reg;

    logic [TCW-1:0] tcnt_x, plen_x, rlen_x, newlen, growth;
    assign tcnt_x = TCW'(tcnt_reg);
    assign plen_x = TCW'(pcnt_reg);
    assign rlen_x = TCW'(rcnt_reg);
    assign growth = rlen_x - plen_x;
    assign newlen = tcnt_x - plen_x + rlen_x;

    logic           t_we;
    logic [TAW-1:0] t_addr;
    logic [7:0]     t_wd;

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = (state_reg == S_OUT);
    assign out_ch.payload = res_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 12'd4095;
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

    // text port address / write
    always_comb
    begin
        t_we   = 1'b0;
        t_wd   = hold_reg;
        t_addr = item_reg.read_index;
        unique case (state_reg)
            S_IDLE: begin
                // a read item fetches its byte right away
                t_addr = (in_ch.payload.operation == OP_READ)
                         ? in_ch.payload.read_index : tcnt_reg;
                t_wd   = in_ch.payload.data_byte;
                t_we   = in_ch.valid && in_ch.payload.operation == OP_APP_TEXT
                         && tcnt_x < TCW'(TEXT_DEPTH - 1);
            end
            S_SRCH, S_SCMP: t_addr = TAW'(pos_reg - 1'b1 + TCW'(k_reg));
            S_MVRD: t_addr = TAW'(pos_reg);
            S_MVWR: begin
                t_we   = 1'b1;
                t_wd   = tq_reg;
                t_addr = grow_reg ? TAW'(pos_reg + growth)
                                  : TAW'(pos_reg - (plen_x - rlen_x));
            end
            S_CPWR: begin
                t_we   = 1'b1;
                t_wd   = rq_reg;
                t_addr = TAW'(TCW'(loc_reg) + TCW'(k_reg));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
            text_mem[t_addr] <= t_wd;
        tq_reg <= text_mem[t_addr];
        pq_reg <= pat_mem[k_reg[SAW-1:0]];
        rq_reg <= rep_mem[k_reg[SAW-1:0]];
        if (state_reg == S_IDLE && in_ch.valid && pcnt_reg < SCW'(STRING_DEPTH)
            && in_ch.payload.operation == OP_APP_PAT)
            pat_mem[pcnt_reg[SAW-1:0]] <= in_ch.payload.data_byte;
        if (state_reg == S_IDLE && in_ch.valid && rcnt_reg < SCW'(STRING_DEPTH)
            && in_ch.payload.operation == OP_APP_REP)
            rep_mem[rcnt_reg[SAW-1:0]] <= in_ch.payload.data_byte;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tcnt_reg  <= '0;
            pcnt_reg  <= '0;
            rcnt_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_ch.valid)
                begin
                    item_reg <= in_ch.payload;
                    res_reg  <= '{ST_OK, 12'd0, 12'(tcnt_reg), 8'd0};
                    k_reg    <= '0;
                    state_reg <= S_OUT;
                    case (in_ch.payload.operation)
                        OP_APP_TEXT:
                            if (tcnt_x >= TCW'(TEXT_DEPTH - 1))
                                res_reg.status <= ST_FULL;
                            else
                            begin
                                tcnt_reg <= tcnt_reg + 1'b1;
                                res_reg.text_length <= 12'(tcnt_reg + 1'b1);
                            end
                        OP_APP_PAT:
                            if (pcnt_reg >= SCW'(STRING_DEPTH))
                                res_reg.status <= ST_FULL;
                            else
                                pcnt_reg <= pcnt_reg + 1'b1;
                        OP_APP_REP:
                            if (rcnt_reg >= SCW'(STRING_DEPTH))
                                res_reg.status <= ST_FULL;
                            else
                                rcnt_reg <= rcnt_reg + 1'b1;
                        OP_EXECUTE:
                            if (pcnt_reg == '0 || plen_x > tcnt_x)
                                res_reg.status <= ST_NOT_FOUND;
                            else
                            begin
                                pos_reg   <= tcnt_x - plen_x + 1'b1;
                                state_reg <= S_SRCH;
                            end
                        OP_READ:
                            if (TCW'(in_ch.payload.read_index) >= tcnt_x)
                                res_reg.status <= ST_RANGE;
                            else
                                state_reg <= S_RDW;
                        OP_CLEAR: begin
                            tcnt_reg <= '0;
                            res_reg.text_length <= 12'd0;
                        end
                        default: ;
                    endcase
                end
                S_RDW: begin
                    res_reg.read_byte <= tq_reg;
                    state_reg <= S_OUT;
                end
                // issue read of text[pos-1+k] and pattern[k]
                S_SRCH: state_reg <= S_SCMP;
                S_SCMP: begin
                    if (fold_case(tq_reg) != fold_case(pq_reg))
                    begin
                        k_reg <= '0;
                        if (pos_reg == TCW'(1))
                        begin
                            res_reg.status <= ST_NOT_FOUND;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            pos_reg <= pos_reg - 1'b1;
                            state_reg <= S_SRCH;
                        end
                    end
                    else if (k_reg == pcnt_reg - 1'b1)
                    begin
                        loc_reg  <= TAW'(pos_reg - 1'b1);
                        grow_reg <= rlen_x > plen_x;
                        mvcnt_reg <= TAW'(tcnt_x - (pos_reg - 1'b1) - plen_x);
                        k_reg <= '0;
                        if (rlen_x > plen_x && (tcnt_x + growth >= TCW'(limit_reg)
                            || tcnt_x + growth > TCW'(TEXT_DEPTH - 1)))
                        begin
                            res_reg.status <= ST_OVERFLOW;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            // grow: move tail from the end; else from the front
                            pos_reg <= (rlen_x > plen_x) ? tcnt_x - 1'b1
                                     : pos_reg - 1'b1 + plen_x;
                            state_reg <= (tcnt_x - (pos_reg - 1'b1) - plen_x == '0)
                                       ? S_CPRD : S_MVRD;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_SRCH;
                    end
                end
                S_MVRD: state_reg <= S_MVWR;
                S_MVWR: begin
                    mvcnt_reg <= mvcnt_reg - 1'b1;
                    pos_reg   <= grow_reg ? pos_reg - 1'b1 : pos_reg + 1'b1;
                    state_reg <= (mvcnt_reg == TAW'(1)) ? S_CPRD : S_MVRD;
                end
                S_CPRD: begin
                    if (k_reg == rcnt_reg)
                    begin
                        tcnt_reg <= TAW'(newlen);
                        res_reg.text_length <= 12'(newlen);
                        res_reg.match_index <= 12'(loc_reg);
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_CPWR;
                end
                S_CPWR: begin
                    k_reg <= k_reg + 1'b1;
                    state_reg <= S_CPRD;
                end
                S_OUT: if (out_ch.ready)
                    state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // hold_reg is spare write data, kept equal to the last text byte read
    always_ff @(posedge clk)
    begin
        hold_reg <= tq_reg;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for text_find_replace_top
// Drives operation items through the input channel, keeps its own copy of the
// text, pattern and replacement stores to work out every result, and checks
// each result item in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb
    import tfr_pkg::*;
();

    localparam int TEXT_CAP = TEXT_DEPTH - 1;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_data;

    tfr_if #(.payload_t(tfr_in_t))  in_ch ();
    tfr_if #(.payload_t(tfr_out_t)) out_ch ();

    text_find_replace_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // predicted block state
    logic [7:0] exp_text [TEXT_DEPTH];
    logic [7:0] exp_pat [STRING_DEPTH];
    logic [7:0] exp_rep [STRING_DEPTH];
    int         text_len;
    int         pat_len;
    int         rep_len;
    int         limit_reg;

    tfr_out_t   pending_results [$];
    int         mismatch_count;
    int         items_sent;
    int         results_seen;
    int         found_count;
    int         overflow_count;
    int         full_count;
    int         no_stall;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #100ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c ^ 8'h20;
        return c;
    endfunction

    // work out the result of one item and update the predicted state
    function automatic tfr_out_t apply_edit(input tfr_in_t it);
        tfr_out_t r;
        int       pos;
        int       k;
        int       loc;
        int       grown;
        bit       hit;
        r = '0;
        case (it.operation)
            OP_APP_TEXT:
                if (text_len >= TEXT_CAP)
                    r.status = ST_FULL;
                else
                begin
                    exp_text[text_len] = it.data_byte;
                    text_len++;
                end
            OP_APP_PAT:
                if (pat_len >= STRING_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    exp_pat[pat_len] = it.data_byte;
                    pat_len++;
                end
            OP_APP_REP:
                if (rep_len >= STRING_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    exp_rep[rep_len] = it.data_byte;
                    rep_len++;
                end
            OP_EXECUTE:
            begin
                hit = 1'b0;
                loc = 0;
                if (pat_len != 0 && pat_len <= text_len)
                begin
                    for (pos = text_len - pat_len; pos >= 0 && !hit; pos--)
                    begin
                        for (k = 0; k < pat_len; k++)
                            if (lower_byte(exp_text[pos + k]) != lower_byte(exp_pat[k]))
                                break;
                        if (k == pat_len)
                        begin
                            hit = 1'b1;
                            loc = pos;
                        end
                    end
                end
                grown = text_len + rep_len - pat_len;
                if (!hit)
                    r.status = ST_NOT_FOUND;
                else if (rep_len > pat_len && (grown >= limit_reg || grown > TEXT_CAP))
                    r.status = ST_OVERFLOW;
                else
                begin
                    // move the tail, then drop in the replacement
                    if (rep_len > pat_len)
                    begin
                        for (k = text_len - 1; k >= loc + pat_len; k--)
                            exp_text[k + rep_len - pat_len] = exp_text[k];
                    end
                    else
                    begin
                        for (k = loc + pat_len; k < text_len; k++)
                            exp_text[k + rep_len - pat_len] = exp_text[k];
                    end
                    for (k = 0; k < rep_len; k++)
                        exp_text[loc + k] = exp_rep[k];
                    text_len = grown;
                    r.match_index = loc[11:0];
                end
            end
            OP_READ:
                if (it.read_index >= text_len)
                    r.status = ST_RANGE;
                else
                    r.read_byte = exp_text[it.read_index];
            OP_CLEAR:
                text_len = 0;
            default: ;
        endcase
        r.text_length = text_len[11:0];
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    always @(posedge clk)
    begin
        static int stall_left = 0;
        if (no_stall != 0)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 9) < 7)
            out_ch.ready <= 1'b1;
        else
        begin
            out_ch.ready <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // result checker
    always @(posedge clk)
    begin
        tfr_out_t want;
        tfr_out_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t unexpected result: status %0d match %0d len %0d byte %0h",
                             $realtime, got.status, got.match_index, got.text_length,
                             got.read_byte);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.match_index != want.match_index ||
                    got.text_length != want.text_length || got.read_byte != want.read_byte)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t result %0d: expected st %0d m %0d len %0d b %0h, got st %0d m %0d len %0d b %0h",
                                 $realtime, results_seen, want.status, want.match_index,
                                 want.text_length, want.read_byte, got.status,
                                 got.match_index, got.text_length, got.read_byte);
                end
            end
        end
    end

    // send one item, predict it when accepted, then idle a while
    task automatic send_item(input logic [2:0] op, input logic [7:0] b,
                             input logic [11:0] idx);
        tfr_in_t  it;
        tfr_out_t r;
        int       gap;
        it.operation  = op;
        it.data_byte  = b;
        it.read_index = idx;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = apply_edit(it);
        pending_results.push_back(r);
        items_sent++;
        if (r.status == ST_OVERFLOW)
            overflow_count++;
        if (r.status == ST_FULL)
            full_count++;
        if (op == OP_EXECUTE && r.status == ST_OK)
            found_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pauses until every result is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input int v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v[11:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        limit_reg = v;
        @(posedge clk);
    endtask

    // pattern-like letters most of the time, any byte otherwise
    function automatic logic [7:0] text_char();
        logic [7:0] letters [6] = '{"a", "b", "c", "A", "B", "C"};
        if ($urandom_range(0, 9) < 8)
            return letters[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_directed();
        send_item(OP_EXECUTE, 8'h00, 12'd0);     // empty pattern, empty text
        send_item(OP_READ, 8'h00, 12'd0);        // read of empty text
        send_item(3'd6, 8'hFF, 12'hFFF);         // unused codes
        send_item(3'd7, 8'h00, 12'd0);
        send_item(OP_APP_PAT, "a", 12'd0);
        send_item(OP_APP_PAT, "B", 12'd0);
        send_item(OP_EXECUTE, 8'h00, 12'd0);     // pattern longer than text
        send_item(OP_APP_TEXT, "x", 12'd0);
        send_item(OP_APP_TEXT, "A", 12'd0);
        send_item(OP_APP_TEXT, "b", 12'd0);
        send_item(OP_APP_TEXT, 8'h00, 12'd0);    // zero byte
        send_item(OP_APP_TEXT, "a", 12'd0);
        send_item(OP_APP_TEXT, "b", 12'd0);
        send_item(OP_APP_TEXT, 8'hFF, 12'd0);
        send_item(OP_EXECUTE, 8'h00, 12'd0);     // empty replacement shrinks
        send_item(OP_READ, 8'h00, 12'd3);
        send_item(OP_READ, 8'h00, 12'd4);
        send_item(OP_READ, 8'h00, 12'd5);        // past the end
        send_item(OP_READ, 8'h00, 12'hFFF);
        send_item(OP_APP_REP, "Q", 12'd0);
        send_item(OP_APP_REP, "r", 12'd0);
        send_item(OP_APP_REP, "s", 12'd0);
        write_limit(6);                          // growth reaches the limit
        send_item(OP_EXECUTE, 8'h00, 12'd0);
        write_limit(7);
        send_item(OP_EXECUTE, 8'h00, 12'd0);     // fits
        send_item(OP_EXECUTE, 8'h00, 12'd0);     // nothing left to match
        send_item(OP_CLEAR, 8'h00, 12'd0);
    endtask

    task automatic test_random_phase(input int count);
        int       n;
        int       p;
        logic [11:0] idx;
        for (n = 0; n < count; n++)
        begin
            p = $urandom_range(0, 99);
            if (text_len > 150)
                send_item(OP_CLEAR, 8'h00, 12'd0);
            else if (p < 45)
                send_item(OP_APP_TEXT, text_char(), 12'd0);
            else if (p < 65)
            begin
                if ($urandom_range(0, 9) < 7)
                    idx = 12'($urandom_range(0, text_len + 2));
                else
                    idx = 12'($urandom_range(0, 4095));
                send_item(OP_READ, 8'($urandom_range(0, 255)), idx);
            end
            else if (p < 82)
                send_item(OP_EXECUTE, 8'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
            else if (p < 85 && pat_len < 8)
                send_item(OP_APP_PAT, text_char(), 12'd0);
            else if (p < 89 && rep_len < 14)
                send_item(OP_APP_REP, text_char(), 12'd0);
            else if (p < 94)
                send_item(OP_CLEAR, 8'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
            else if (p < 96)
                send_item(3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
            else
                send_item(OP_APP_TEXT, text_char(), 12'd0);
            // stretches with no idling on the receive side
            if (n % 200 == 100)
                no_stall = 1;
            else if (n % 200 == 140)
                no_stall = 0;
        end
    endtask

    task automatic test_string_capacity();
        int i;
        write_limit(4095);
        send_item(OP_CLEAR, 8'h00, 12'd0);
        while (pat_len < STRING_DEPTH)
            send_item(OP_APP_PAT, text_char(), 12'd0);
        send_item(OP_APP_PAT, "x", 12'd0);       // store full
        while (rep_len < STRING_DEPTH)
            send_item(OP_APP_REP, 8'($urandom_range(0, 255)), 12'd0);
        send_item(OP_APP_REP, "x", 12'd0);       // store full
        send_item(OP_EXECUTE, 8'h00, 12'd0);     // text shorter than pattern
        for (i = 0; i < 3; i++)
            send_item(OP_APP_TEXT, "z", 12'd0);
        // full pattern with letter case flipped
        for (i = 0; i < STRING_DEPTH; i++)
        begin
            if ((exp_pat[i] >= "a" && exp_pat[i] <= "z") ||
                (exp_pat[i] >= "A" && exp_pat[i] <= "Z"))
                send_item(OP_APP_TEXT, exp_pat[i] ^ 8'h20, 12'd0);
            else
                send_item(OP_APP_TEXT, exp_pat[i], 12'd0);
        end
        send_item(OP_EXECUTE, 8'h00, 12'd0);     // equal-length replace
        send_item(OP_READ, 8'h00, 12'd3);
        send_item(OP_READ, 8'h00, 12'd258);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        text_len       = 0;
        pat_len        = 0;
        rep_len        = 0;
        limit_reg      = 4095;
        mismatch_count = 0;
        items_sent     = 0;
        results_seen   = 0;
        found_count    = 0;
        overflow_count = 0;
        full_count     = 0;
        no_stall       = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_limit(4095);
        test_random_phase(150);
        write_limit(1);
        test_random_phase(100);
        write_limit($urandom_range(20, 200));
        test_random_phase(150);
        test_string_capacity();

        wait_drained();
        repeat (50) @(posedge clk);
        $display("Run covered %0d items, %0d results: %0d replacements, %0d overflows,",
                 items_sent, results_seen, found_count, overflow_count);
        $display("%0d store-full answers, %0d mismatches.", full_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
